### sv/rrsb_pkg.sv
// Shared types and constants of the round-robin slice-budget scheduler.
`default_nettype none

package rrsb_pkg;

  localparam int unsigned ID_W    = 16;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned QCNT_W  = 4;
  localparam int unsigned ENTRY_W = ID_W + CNT_W;

  localparam logic [CNT_W-1:0] MAX_SLICES_RESET = CNT_W'(5);

  // Item kinds
  typedef enum logic {
    KIND_ADMIT = 1'b0,
    KIND_SLICE = 1'b1
  } kind_t;

  // Input word
  typedef struct packed {
    kind_t           kind;
    logic [ID_W-1:0] task_id;
    logic            still_runnable;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic              grant_valid;
    logic [ID_W-1:0]   granted_task;
    logic [CNT_W-1:0]  slices_used;
    logic              retired;
    logic              admit_dropped;
    logic [QCNT_W-1:0] queue_count;
  } out_word_t;

  // One ring entry: slice count above the task identifier
  typedef struct packed {
    logic [CNT_W-1:0] slices;
    logic [ID_W-1:0]  id;
  } entry_t;

endpackage

`default_nettype wire

### sv/rrsb_in_if.sv
// Valid/ready channel carrying scheduler input words.
`default_nettype none

interface rrsb_in_if;
  import rrsb_pkg::*;

  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### sv/rrsb_out_if.sv
// Valid/ready channel carrying scheduler result words.
`default_nettype none

interface rrsb_out_if;
  import rrsb_pkg::*;

  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### sv/rrsb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rrsb_ram #(
  parameter int unsigned WIDTH = 20,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### sv/round_robin_slice_budget_scheduler.sv
// Round-robin task scheduler with a per-task slice budget.
//
// Input channel in_ch carries one word per item: an admit puts task_id at
// the tail of the ready ring with zero slices used (or flags admit_dropped
// when the ring is full); a slice pops the head task, grants it a quantum
// and bumps its slice count. The task retires when the count reaches
// max_slices, else it goes back to the tail if still_runnable is set.
// Every input word yields exactly one result word on out_ch.
// cfg_we/cfg_wdata write max_slices; write it only while the block is idle.
// The result is registered, in the cycle after the input is taken.
// Throughput: one item per cycle. The ring RAM is read every cycle at the
// next head position, so the head entry is always staged for the next pop;
// a same-cycle write to that slot is forwarded through a bypass register.
// Reset clears head, tail, count and output valid and loads max_slices
// with 5; ring contents are not cleared and need no clearing pass.
// When the receiver stalls, the result waits in the output register and
// in_ch.ready stays low until it is taken.
`default_nettype none

module round_robin_slice_budget_scheduler #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  rrsb_in_if.sink                        in_ch,
  rrsb_out_if.source                     out_ch,
  input  wire logic                      cfg_we,
  input  wire logic [rrsb_pkg::CNT_W-1:0] cfg_wdata
);
  import rrsb_pkg::*;

  localparam int unsigned IW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic [IW-1:0]    head_r, head_nxt;
  logic [IW-1:0]    tail_r, tail_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0] max_r;
  logic             byp_r, byp_nxt;
  entry_t           byp_data_r;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_r, out_nxt;

  entry_t           ram_rdata;
  entry_t           head_entry;
  entry_t           wr_data;
  logic             accept, is_admit, full, pop, push_admit, requeue, wr_en, retire;
  logic [CNT_W-1:0] used;

  function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] pos);
    return (pos == IW'(QUEUE_DEPTH - 1)) ? '0 : pos + IW'(1);
  endfunction

  // Ring storage, read every cycle at the next head position
  rrsb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (wr_en),
    .waddr (tail_r),
    .wdata (wr_data),
    .raddr (head_nxt),
    .rdata (ram_rdata)
  );

  // Handshake
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign accept       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  // Head entry, with forwarding of a write that landed on the read slot
  assign head_entry = byp_r ? byp_data_r : ram_rdata;

  // Item decode and queue update
  always_comb begin
    is_admit   = (in_ch.data.kind == KIND_ADMIT);
    full       = (count_r == CW'(QUEUE_DEPTH));
    pop        = accept && !is_admit && (count_r != '0);
    push_admit = accept && is_admit && !full;
    used       = head_entry.slices + CNT_W'(1);
    retire     = (used >= max_r);
    requeue    = pop && !retire && in_ch.data.still_runnable;
    wr_en      = push_admit || requeue;

    wr_data = '0;
    if (push_admit) begin
      wr_data.id = in_ch.data.task_id;
    end else begin
      wr_data.id     = head_entry.id;
      wr_data.slices = used;
    end

    head_nxt = pop   ? ring_next(head_r) : head_r;
    tail_nxt = wr_en ? ring_next(tail_r) : tail_r;

    count_nxt = count_r;
    if (push_admit) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !requeue) begin
      count_nxt = count_r - CW'(1);
    end

    byp_nxt = wr_en && (tail_r == head_nxt);
  end

  // Result word
  always_comb begin
    out_nxt               = '0;
    out_nxt.grant_valid   = pop;
    out_nxt.granted_task  = pop ? head_entry.id : '0;
    out_nxt.slices_used   = pop ? used : '0;
    out_nxt.retired       = pop && retire;
    out_nxt.admit_dropped = accept && is_admit && full;
    out_nxt.queue_count   = QCNT_W'(count_nxt);
  end

  assign out_valid_nxt = accept ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      max_r       <= MAX_SLICES_RESET;
      byp_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        head_r  <= head_nxt;
        tail_r  <= tail_nxt;
        count_r <= count_nxt;
      end
      if (cfg_we) begin
        max_r <= cfg_wdata;
      end
      byp_r       <= byp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    byp_data_r <= wr_data;
    if (accept) begin
      out_r <= out_nxt;
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("waiting count exceeds ring depth");

  a_empty_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !is_admit && (count_r == '0) |=> out_valid_r && !out_r.grant_valid)
    else $error("grant issued from an empty ring");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_admit && full |=> out_r.admit_dropped && $stable(count_r))
    else $error("admit into a full ring not dropped");

  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(head_r) && $stable(tail_r) && $stable(count_r))
    else $error("queue state moved without an item");

  a_retire_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.retired |-> out_r.grant_valid && (out_r.slices_used >= max_r))
    else $error("task retired below its slice budget");

  a_bypass_src: assert property (@(posedge clk) disable iff (!rst_n)
    byp_r |-> $past(wr_en))
    else $error("bypass set without a ring write");

endmodule

`default_nettype wire

### tb/round_robin_slice_budget_scheduler_test.sv
// Self-checking testbench for the round-robin slice-budget scheduler.
module round_robin_slice_budget_scheduler_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rrsb_pkg::*;

  localparam int unsigned QDEPTH       = 8;
  localparam int unsigned CLK_PERIOD   = 10;
  localparam int unsigned CYCLE_LIMIT  = 800_000;
  localparam int unsigned PHASE_WORDS  = 230;
  localparam int unsigned SQUEEZE_AT   = 300;
  localparam int unsigned SQUEEZE_LEN  = 400;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // Configuration port
  logic             cfg_we    = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;

  // Channel drive
  logic     drv_valid = 1'b0;
  in_word_t drv_word  = '0;
  logic     rx_ready  = 1'b0;

  rrsb_in_if  in_ch ();
  rrsb_out_if out_ch ();

  assign in_ch.valid  = drv_valid;
  assign in_ch.data   = drv_word;
  assign out_ch.ready = rx_ready;

  round_robin_slice_budget_scheduler #(
    .QUEUE_DEPTH (QDEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Scheduler shadow: ring of tasks, pointers, fill level and slice budget
  entry_t           ring_q [QDEPTH];
  int unsigned      ring_head   = 0;
  int unsigned      ring_tail   = 0;
  int unsigned      ring_fill   = 0;
  logic [CNT_W-1:0] slice_limit = MAX_SLICES_RESET;

  in_word_t    stim_words[$];
  out_word_t   pending_results[$];
  int unsigned fail_count   = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_count  = 0;
  int unsigned tx_gap       = 0;
  int unsigned rx_hold      = 0;
  logic        squeeze_done = 1'b0;
  logic        tx_steady    = 1'b0;
  logic        rx_steady    = 1'b0;

  function automatic void ring_push(logic [ID_W-1:0] id, logic [CNT_W-1:0] slices);
    ring_q[ring_tail].id     = id;
    ring_q[ring_tail].slices = slices;
    ring_tail = (ring_tail + 1) % QDEPTH;
    ring_fill++;
  endfunction

  // Apply one input word to the shadow and return the result word it yields
  function automatic out_word_t schedule_word(in_word_t w);
    out_word_t r;
    entry_t    e;
    r = '0;
    if (w.kind == KIND_ADMIT) begin
      if (ring_fill >= QDEPTH) r.admit_dropped = 1'b1;
      else ring_push(w.task_id, '0);
    end else if (ring_fill > 0) begin
      e = ring_q[ring_head];
      ring_head = (ring_head + 1) % QDEPTH;
      ring_fill--;
      r.grant_valid  = 1'b1;
      r.granted_task = e.id;
      r.slices_used  = e.slices + CNT_W'(1);
      // budget compare is against the raw register, zero retires at once
      if (r.slices_used >= slice_limit) r.retired = 1'b1;
      else if (w.still_runnable) ring_push(e.id, r.slices_used);
    end
    r.queue_count = QCNT_W'(ring_fill);
    return r;
  endfunction

  // Mostly zero, often short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [ID_W-1:0] pick_task_id();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return ID_W'($urandom);
  endfunction

  function automatic void add_word(kind_t k, logic [ID_W-1:0] id, logic runnable);
    in_word_t w;
    w.kind           = k;
    w.task_id        = id;
    w.still_runnable = runnable;
    stim_words.push_back(w);
  endfunction

  // Alternating bursts of admits and slices, with some kinds flipped as noise
  function automatic void add_random_words(int unsigned n);
    int unsigned left;
    int unsigned burst;
    logic        admit_mode;
    kind_t       k;
    left       = n;
    admit_mode = 1'b1;
    while (left > 0) begin
      burst = $urandom_range(1, admit_mode ? 10 : 14);
      if (burst > left) burst = left;
      repeat (burst) begin
        k = admit_mode ? KIND_ADMIT : KIND_SLICE;
        if ($urandom_range(0, 7) == 0) k = (k == KIND_ADMIT) ? KIND_SLICE : KIND_ADMIT;
        add_word(k, pick_task_id(), $urandom_range(0, 3) != 0);
      end
      left       = left - burst;
      admit_mode = ~admit_mode;
    end
  endfunction

  task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", fname, want, got);
      fail_count++;
    end
  endtask

  // Block until no word is queued, offered or awaiting its result
  task automatic wait_drained();
    @(negedge clk);
    while (stim_words.size() != 0 || drv_valid || pending_results.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_slice_limit(logic [CNT_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    slice_limit = v;
    @(negedge clk);
  endtask

  // Sender: next word after an accept, with random gaps between words
  always @(posedge clk) begin
    if (!rst_n) begin
      drv_valid <= 1'b0;
      tx_gap    <= 0;
    end else if (!drv_valid || in_ch.ready) begin
      if (tx_gap != 0) begin
        drv_valid <= 1'b0;
        tx_gap    <= tx_gap - 1;
      end else if (stim_words.size() != 0) begin
        drv_word  <= stim_words.pop_front();
        drv_valid <= 1'b1;
        tx_gap    <= tx_steady ? 0 : pick_gap();
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off to back up the input
  always @(posedge clk) begin : rx_side
    int unsigned g;
    if (!rst_n) begin
      rx_ready <= 1'b0;
    end else if (rx_hold != 0) begin
      rx_ready <= 1'b0;
      rx_hold  <= rx_hold - 1;
    end else if (!squeeze_done && results_seen >= SQUEEZE_AT) begin
      rx_ready     <= 1'b0;
      rx_hold      <= SQUEEZE_LEN;
      squeeze_done <= 1'b1;
    end else if (rx_steady) begin
      rx_ready <= 1'b1;
    end else begin
      g = pick_gap();
      rx_ready <= (g == 0);
      if (g != 0) rx_hold <= g - 1;
    end
  end

  // Monitor: check taken results first, then predict for the word taken
  always @(posedge clk) begin : monitor
    out_word_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen <= results_seen + 1;
        if (pending_results.size() == 0) begin
          $error("unexpected result word %h", out_ch.data);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("grant_valid", 32'(want.grant_valid),
                      32'(out_ch.data.grant_valid));
          check_field("granted_task", 32'(want.granted_task),
                      32'(out_ch.data.granted_task));
          check_field("slices_used", 32'(want.slices_used),
                      32'(out_ch.data.slices_used));
          check_field("retired", 32'(want.retired),
                      32'(out_ch.data.retired));
          check_field("admit_dropped", 32'(want.admit_dropped),
                      32'(out_ch.data.admit_dropped));
          check_field("queue_count", 32'(want.queue_count),
                      32'(out_ch.data.queue_count));
        end
      end
      if (in_ch.valid && in_ch.ready)
        pending_results.push_back(schedule_word(in_ch.data));
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    logic [CNT_W-1:0] limit_plan [8];
    logic [CNT_W-1:0] lim;
    limit_plan = '{4'd15, 4'd1, 4'd0, 4'd9, 4'd3, 4'd15, 4'd6, 4'd1};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words at the reset budget
    add_word(KIND_SLICE, '1, 1'b1);               // slice on an empty ring
    add_word(KIND_ADMIT, '0, 1'b0);
    repeat (5) add_word(KIND_SLICE, '0, 1'b1);    // same task up to retirement
    add_word(KIND_ADMIT, '1, 1'b1);
    add_word(KIND_SLICE, '1, 1'b0);               // granted, then discarded
    for (int i = 0; i < 9; i++)                   // fill, then one dropped
      add_word(KIND_ADMIT, pick_task_id(), i[0]);
    for (int i = 0; i < 8; i++)                   // first one requeues from full
      add_word(KIND_SLICE, pick_task_id(), !i[0]);
    wait_drained();

    // Random phases over a range of budgets
    for (int ph = 0; ph < 8; ph++) begin
      lim = (ph == 6) ? CNT_W'($urandom_range(0, 15)) : limit_plan[ph];
      set_slice_limit(lim);
      tx_steady = (ph % 3 == 1);
      rx_steady = (ph % 4 == 2);
      add_random_words(PHASE_WORDS);
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

### round_robin_slice_budget_scheduler.f
sv/rrsb_pkg.sv
sv/rrsb_in_if.sv
sv/rrsb_out_if.sv
sv/rrsb_ram.sv
sv/round_robin_slice_budget_scheduler.sv
tb/round_robin_slice_budget_scheduler_test.sv
